// ----- rtl/core/qrpt_pkg.sv -----
// Shared types, widths and helpers for the quaternion rigid point transform.
// No dependencies.
package qrpt_pkg;

  localparam int QuatW    = 16;
  localparam int PointW   = 24;
  localparam int EntryW   = 16;
  localparam int OffW     = 20;
  localparam int RowW     = 48;
  localparam int OffRegW  = 60;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 60;
  localparam int NumLanes = 9;
  localparam int MagW     = 32;
  localparam int N2W      = 33;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GI_ROW0 = 3'd0,
    CFG_GI_ROW1 = 3'd1,
    CFG_GI_ROW2 = 3'd2,
    CFG_CG_ROW0 = 3'd3,
    CFG_CG_ROW1 = 3'd4,
    CFG_CG_ROW2 = 3'd5,
    CFG_CAM_OFF = 3'd6
  } cfg_idx_e;

  typedef logic signed [EntryW-1:0] entry_t;
  typedef logic signed [PointW-1:0] point_t;

  function automatic entry_t row_entry(input logic [RowW-1:0] row, input int c);
    return entry_t'(row[EntryW*c +: EntryW]);
  endfunction

  function automatic logic signed [OffW-1:0] off_entry(input logic [OffRegW-1:0] v,
                                                       input int c);
    return v[OffW*c +: OffW];
  endfunction

  function automatic entry_t sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'sh7fff;
    end else if (v < -64'sd32768) begin
      return 16'sh8000;
    end
    return v[EntryW-1:0];
  endfunction

  function automatic point_t sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) begin
      return 24'sh7fffff;
    end else if (v < -64'sd8388608) begin
      return 24'sh800000;
    end
    return v[PointW-1:0];
  endfunction

  // round half up, then arithmetic shift right by s (s >= 1)
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

endpackage

// ----- rtl/core/qrpt_div.sv -----
// Nine-lane restoring divider pipeline, one quotient bit per stage.
// Computes round(2*mag*2^RF / n2) and carries a side payload along. Uses qrpt_pkg.
module qrpt_div import qrpt_pkg::*; #(
  parameter int ROT_FRAC_BITS = 14,
  parameter int SIDE_W        = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [MagW-1:0]            mag_i [NumLanes],
  input  logic [N2W-1:0]             n2_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [ROT_FRAC_BITS+1:0]   quot_o [NumLanes],
  output logic [SIDE_W-1:0]          side_o
);

  localparam int QB = ROT_FRAC_BITS + 2;
  localparam int NW = MagW + ROT_FRAC_BITS + 3;
  localparam int DW = N2W + 1;

  logic [NW-1:0]     rem_c  [QB+1][NumLanes];
  logic [QB-1:0]     quo_c  [QB+1][NumLanes];
  logic [DW-1:0]     den_c  [QB+1];
  logic [SIDE_W-1:0] side_c [QB+1];
  logic [QB:0]       vld_c;

  logic [NW-1:0]     rem_q  [QB][NumLanes];
  logic [QB-1:0]     quo_q  [QB][NumLanes];
  logic [DW-1:0]     den_q  [QB];
  logic [SIDE_W-1:0] side_q [QB];
  logic [QB-1:0]     vld_q;

  always_comb begin
    den_c[0]  = DW'(n2_i) << 1;
    side_c[0] = side_i;
    vld_c[0]  = valid_i;
    for (int l = 0; l < NumLanes; l++) begin
      rem_c[0][l] = (NW'(mag_i[l]) << (ROT_FRAC_BITS + 2)) + NW'(n2_i);
      quo_c[0][l] = '0;
    end
    for (int s = 0; s < QB; s++) begin
      den_c[s+1]  = den_q[s];
      side_c[s+1] = side_q[s];
      vld_c[s+1]  = vld_q[s];
      for (int l = 0; l < NumLanes; l++) begin
        rem_c[s+1][l] = rem_q[s][l];
        quo_c[s+1][l] = quo_q[s][l];
      end
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int Bit = QB - 1 - s;
    logic [NW-1:0] trial [NumLanes];
    logic [NW:0]   diff  [NumLanes];
    logic [NW-1:0] rem_d [NumLanes];
    logic [QB-1:0] quo_d [NumLanes];

    always_comb begin
      for (int l = 0; l < NumLanes; l++) begin
        trial[l] = NW'(den_c[s]) << Bit;
        diff[l]  = {1'b0, rem_c[s][l]} - {1'b0, trial[l]};
        if (!diff[l][NW]) begin
          rem_d[l] = diff[l][NW-1:0];
          quo_d[l] = quo_c[s][l] | (QB'(1) << Bit);
        end else begin
          rem_d[l] = rem_c[s][l];
          quo_d[l] = quo_c[s][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_c[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s]  <= den_c[s];
        side_q[s] <= side_c[s];
        for (int l = 0; l < NumLanes; l++) begin
          rem_q[s][l] <= rem_d[l];
          quo_q[s][l] <= quo_d[l];
        end
      end
    end
  end

  assign valid_o = vld_c[QB];
  assign side_o  = side_c[QB];
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      quot_o[l] = quo_c[QB][l];
    end
  end

endmodule

// ----- rtl/core/quaternion_rigid_point_transform.sv -----
// Top level: camera point to gimbal and world frames through a normalized IMU quaternion.
// Uses qrpt_pkg and qrpt_div.
//
//   port group   dir  handshake              carries
//   in_*         in   in_valid_i/in_stall_o  cam point, quaternion
//   out_*        out  out_valid_o/out_stall_i valid_res, gimbal/world points, matrix rows
//   cfg_*        in   cfg_valid_i/cfg_ready_o register index and data
//
// One transfer per cycle in each direction while the output is not stalled; each result
// passes through the bit-per-stage quotient pipeline and then the matrix chain.
// Reset clears the valid bits and all config registers to zero.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module quaternion_rigid_point_transform import qrpt_pkg::*; #(
  parameter int ROT_FRAC_BITS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [23:0]  cam_x_i,
  input  logic signed [23:0]  cam_y_i,
  input  logic signed [23:0]  cam_z_i,
  input  logic signed [15:0]  quat_w_i,
  input  logic signed [15:0]  quat_x_i,
  input  logic signed [15:0]  quat_y_i,
  input  logic signed [15:0]  quat_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                valid_res_o,
  output logic signed [23:0]  gimbal_x_o,
  output logic signed [23:0]  gimbal_y_o,
  output logic signed [23:0]  gimbal_z_o,
  output logic signed [23:0]  world_x_o,
  output logic signed [23:0]  world_y_o,
  output logic signed [23:0]  world_z_o,
  output logic [47:0]         world_rot_row0_o,
  output logic [47:0]         world_rot_row1_o,
  output logic [47:0]         world_rot_row2_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [59:0]         cfg_data_i
);

  localparam int RF   = ROT_FRAC_BITS;
  localparam int QB   = RF + 2;
  localparam int GAW  = 42;
  localparam int GW   = 43 - RF;
  localparam int WW   = GW + 18;
  localparam int BW   = 34;
  localparam int MAW  = 52;
  localparam int SW   = 1 + NumLanes + 3 * GW;
  localparam logic [QB-1:0] QMax = QB'(1) << (RF + 1);

  // product slots
  localparam int PWW = 0, PXX = 1, PYY = 2, PZZ = 3, PXY = 4;
  localparam int PZW = 5, PXZ = 6, PYW = 7, PYZ = 8, PXW = 9;

  logic en;
  logic out_valid_q;

  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // configuration
  logic [RowW-1:0]    gi_q [3];
  logic [RowW-1:0]    cg_q [3];
  logic [OffRegW-1:0] off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gi_q  <= '{default: '0};
      cg_q  <= '{default: '0};
      off_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GI_ROW0: gi_q[0] <= cfg_data_i[RowW-1:0];
        CFG_GI_ROW1: gi_q[1] <= cfg_data_i[RowW-1:0];
        CFG_GI_ROW2: gi_q[2] <= cfg_data_i[RowW-1:0];
        CFG_CG_ROW0: cg_q[0] <= cfg_data_i[RowW-1:0];
        CFG_CG_ROW1: cg_q[1] <= cfg_data_i[RowW-1:0];
        CFG_CG_ROW2: cg_q[2] <= cfg_data_i[RowW-1:0];
        CFG_CAM_OFF: off_q   <= cfg_data_i[OffRegW-1:0];
        default: ;
      endcase
    end
  end

  entry_t                 a_m  [3][3];
  entry_t                 rc_m [3][3];
  logic signed [OffW-1:0] off_v [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        a_m[r][c]  = row_entry(gi_q[r], c);
        rc_m[r][c] = row_entry(cg_q[r], c);
      end
      off_v[r] = off_entry(off_q, r);
    end
  end

  // stage 1: input register
  logic                     v1_q;
  logic signed [PointW-1:0] p1_q [3];
  logic signed [QuatW-1:0]  qw1_q, qx1_q, qy1_q, qz1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q[0] <= cam_x_i;
      p1_q[1] <= cam_y_i;
      p1_q[2] <= cam_z_i;
      qw1_q   <= quat_w_i;
      qx1_q   <= quat_x_i;
      qy1_q   <= quat_y_i;
      qz1_q   <= quat_z_i;
    end
  end

  // stage 2: quaternion products, camera rotation
  logic                  v2_q;
  logic signed [31:0]    pr2_d [10];
  logic signed [31:0]    pr2_q [10];
  logic signed [GAW-1:0] ga2_d [3];
  logic signed [GAW-1:0] ga2_q [3];

  always_comb begin
    pr2_d[PWW] = 32'(qw1_q) * 32'(qw1_q);
    pr2_d[PXX] = 32'(qx1_q) * 32'(qx1_q);
    pr2_d[PYY] = 32'(qy1_q) * 32'(qy1_q);
    pr2_d[PZZ] = 32'(qz1_q) * 32'(qz1_q);
    pr2_d[PXY] = 32'(qx1_q) * 32'(qy1_q);
    pr2_d[PZW] = 32'(qz1_q) * 32'(qw1_q);
    pr2_d[PXZ] = 32'(qx1_q) * 32'(qz1_q);
    pr2_d[PYW] = 32'(qy1_q) * 32'(qw1_q);
    pr2_d[PYZ] = 32'(qy1_q) * 32'(qz1_q);
    pr2_d[PXW] = 32'(qx1_q) * 32'(qw1_q);
    for (int i = 0; i < 3; i++) begin
      ga2_d[i] = '0;
      for (int k = 0; k < 3; k++) begin
        ga2_d[i] = ga2_d[i] + GAW'(rc_m[i][k]) * GAW'(p1_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr2_q <= pr2_d;
      ga2_q <= ga2_d;
    end
  end

  // stage 3: norm, product pairs, gimbal point
  logic                 v3_q;
  logic signed [32:0]   pv3 [NumLanes];
  logic [MagW-1:0]      mag3_d [NumLanes];
  logic [MagW-1:0]      mag3_q [NumLanes];
  logic [NumLanes-1:0]  neg3_d, neg3_q;
  logic [N2W-1:0]       n2_3_d, n2_3_q;
  logic signed [GW-1:0] g3_d [3];
  logic signed [GW-1:0] g3_q [3];
  logic signed [32:0]   abs3;

  always_comb begin
    n2_3_d = N2W'($unsigned(pr2_q[PWW])) + N2W'($unsigned(pr2_q[PXX]))
           + N2W'($unsigned(pr2_q[PYY])) + N2W'($unsigned(pr2_q[PZZ]));
    pv3[0] = 33'(pr2_q[PYY]) + 33'(pr2_q[PZZ]);
    pv3[1] = 33'(pr2_q[PXY]) - 33'(pr2_q[PZW]);
    pv3[2] = 33'(pr2_q[PXZ]) + 33'(pr2_q[PYW]);
    pv3[3] = 33'(pr2_q[PXY]) + 33'(pr2_q[PZW]);
    pv3[4] = 33'(pr2_q[PXX]) + 33'(pr2_q[PZZ]);
    pv3[5] = 33'(pr2_q[PYZ]) - 33'(pr2_q[PXW]);
    pv3[6] = 33'(pr2_q[PXZ]) - 33'(pr2_q[PYW]);
    pv3[7] = 33'(pr2_q[PYZ]) + 33'(pr2_q[PXW]);
    pv3[8] = 33'(pr2_q[PXX]) + 33'(pr2_q[PYY]);
    abs3   = '0;
    for (int l = 0; l < NumLanes; l++) begin
      neg3_d[l] = pv3[l][32];
      abs3      = neg3_d[l] ? -pv3[l] : pv3[l];
      mag3_d[l] = abs3[MagW-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      g3_d[i] = GW'(rnd_shr(64'(ga2_q[i]), RF) + 64'(off_v[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag3_q <= mag3_d;
      neg3_q <= neg3_d;
      n2_3_q <= n2_3_d;
      g3_q   <= g3_d;
    end
  end

  // quotient pipeline
  logic          vd;
  logic [QB-1:0] quot_d [NumLanes];
  logic [SW-1:0] side_d;

  qrpt_div #(
    .ROT_FRAC_BITS (RF),
    .SIDE_W        (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .mag_i   (mag3_q),
    .n2_i    (n2_3_q),
    .side_i  ({n2_3_q != '0, neg3_q, g3_q[2], g3_q[1], g3_q[0]}),
    .valid_o (vd),
    .quot_o  (quot_d),
    .side_o  (side_d)
  );

  logic                 qnz_d;
  logic [NumLanes-1:0]  neg_d;
  logic signed [GW-1:0] g_d [3];

  assign qnz_d = side_d[SW-1];
  assign neg_d = side_d[SW-2 -: NumLanes];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_d[i] = side_d[i*GW +: GW];
    end
  end

  // stage R: rotation entries
  logic                 vr_q, qnz_r_q;
  entry_t               rq_d [3][3];
  entry_t               rq_q [3][3];
  logic signed [GW-1:0] g_r_q [3];
  logic signed [63:0]   qv;

  always_comb begin
    qv = '0;
    for (int k = 0; k < 3; k++) begin
      for (int l = 0; l < 3; l++) begin
        qv = 64'(quot_d[3*k+l]);
        if (k == l) begin
          rq_d[k][l] = sat16((64'sd1 <<< RF) - qv);
        end else begin
          rq_d[k][l] = sat16(neg_d[3*k+l] ? -qv : qv);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rq_q    <= rq_d;
      g_r_q   <= g_d;
      qnz_r_q <= qnz_d;
    end
  end

  // stage M1: Rq * A
  logic                 vm1_q, qnz_m1_q;
  logic signed [BW-1:0] b_d [3][3];
  logic signed [BW-1:0] b_q [3][3];
  logic signed [GW-1:0] g_m1_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        b_d[k][j] = '0;
        for (int l = 0; l < 3; l++) begin
          b_d[k][j] = b_d[k][j] + BW'(rq_q[k][l]) * BW'(a_m[l][j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q      <= b_d;
      g_m1_q   <= g_r_q;
      qnz_m1_q <= qnz_r_q;
    end
  end

  // stage M2: A^T * (Rq * A) at full precision
  logic                  vm2_q, qnz_m2_q;
  logic signed [MAW-1:0] ma_d [3][3];
  logic signed [MAW-1:0] ma_q [3][3];
  logic signed [GW-1:0]  g_m2_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ma_d[i][j] = '0;
        for (int k = 0; k < 3; k++) begin
          ma_d[i][j] = ma_d[i][j] + MAW'(a_m[k][i]) * MAW'(b_q[k][j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ma_q     <= ma_d;
      g_m2_q   <= g_m1_q;
      qnz_m2_q <= qnz_m1_q;
    end
  end

  // stage M3: round and saturate matrix
  logic                 vm3_q, qnz_m3_q;
  entry_t               mt_d [3][3];
  entry_t               mt_q [3][3];
  logic signed [GW-1:0] g_m3_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mt_d[i][j] = sat16(rnd_shr(64'(ma_q[i][j]), 2 * RF));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mt_q     <= mt_d;
      g_m3_q   <= g_m2_q;
      qnz_m3_q <= qnz_m2_q;
    end
  end

  // stage M4: world accumulation
  logic                 vm4_q, qnz_m4_q;
  logic signed [WW-1:0] wa_d [3];
  logic signed [WW-1:0] wa_q [3];
  entry_t               mt_m4_q [3][3];
  logic signed [GW-1:0] g_m4_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wa_d[i] = '0;
      for (int k = 0; k < 3; k++) begin
        wa_d[i] = wa_d[i] + WW'(mt_q[i][k]) * WW'(g_m3_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wa_q     <= wa_d;
      mt_m4_q  <= mt_q;
      g_m4_q   <= g_m3_q;
      qnz_m4_q <= qnz_m3_q;
    end
  end

  // output register
  point_t          gp_d [3];
  point_t          wp_d [3];
  logic [RowW-1:0] row_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gp_d[i]  = '0;
      wp_d[i]  = '0;
      row_d[i] = '0;
      if (qnz_m4_q) begin
        gp_d[i]  = sat24(64'(g_m4_q[i]));
        wp_d[i]  = sat24(rnd_shr(64'(wa_q[i]), RF));
        row_d[i] = {mt_m4_q[i][2], mt_m4_q[i][1], mt_m4_q[i][0]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      valid_res_o      <= qnz_m4_q;
      gimbal_x_o       <= gp_d[0];
      gimbal_y_o       <= gp_d[1];
      gimbal_z_o       <= gp_d[2];
      world_x_o        <= wp_d[0];
      world_y_o        <= wp_d[1];
      world_z_o        <= wp_d[2];
      world_rot_row0_o <= row_d[0];
      world_rot_row1_o <= row_d[1];
      world_rot_row2_o <= row_d[2];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      vr_q        <= 1'b0;
      vm1_q       <= 1'b0;
      vm2_q       <= 1'b0;
      vm3_q       <= 1'b0;
      vm4_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      vr_q        <= vd;
      vm1_q       <= vr_q;
      vm2_q       <= vm1_q;
      vm3_q       <= vm2_q;
      vm4_q       <= vm3_q;
      out_valid_q <= vm4_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> gimbal_x_o == '0 && world_x_o == '0
                                    && world_rot_row0_o == '0)
    else $error("zero quaternion result carries nonzero fields");

  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> out_valid_o == $past(vm4_q))
    else $error("output valid does not follow last pipeline stage");

  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd && qnz_d |-> quot_d[0] <= QMax && quot_d[1] <= QMax)
    else $error("quotient exceeds expected bound");
`endif

endmodule

// ----- bench/qrpt_checker.sv -----
// Checker for the quaternion rigid point transform: watches config writes,
// input and output transfers, predicts each result and compares it.
// Depends on qrpt_pkg.
`timescale 1ns / 100ps

module qrpt_checker import qrpt_pkg::*; #(
  parameter int ROT_FRAC_BITS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  logic signed [23:0]  cam_x_i,
  input  logic signed [23:0]  cam_y_i,
  input  logic signed [23:0]  cam_z_i,
  input  logic signed [15:0]  quat_w_i,
  input  logic signed [15:0]  quat_x_i,
  input  logic signed [15:0]  quat_y_i,
  input  logic signed [15:0]  quat_z_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic                valid_res_o,
  input  logic signed [23:0]  gimbal_x_o,
  input  logic signed [23:0]  gimbal_y_o,
  input  logic signed [23:0]  gimbal_z_o,
  input  logic signed [23:0]  world_x_o,
  input  logic signed [23:0]  world_y_o,
  input  logic signed [23:0]  world_z_o,
  input  logic [47:0]         world_rot_row0_o,
  input  logic [47:0]         world_rot_row1_o,
  input  logic [47:0]         world_rot_row2_o,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [59:0]         cfg_data_i,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic         ok;
    logic [23:0]  gx, gy, gz, wx, wy, wz;
    logic [47:0]  r0, r1, r2;
  } pose_t;

  pose_t       pose_q[$];
  logic [59:0] regs[7];

  function automatic longint sx(longint v, int w);
    longint m;
    m = longint'(1) << (w - 1);
    v = v & ((longint'(1) << w) - 1);
    return (v ^ m) - m;
  endfunction

  function automatic longint clip(longint v, int w);
    longint hi;
    hi = (longint'(1) << (w - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint quat_ratio(longint p, longint n2);
    longint mag, q;
    mag = p < 0 ? -p : p;
    q = ((mag << (ROT_FRAC_BITS + 2)) + n2) / (n2 * 2);
    return p < 0 ? -q : q;
  endfunction

  function automatic pose_t predict_pose(longint px, longint py, longint pz,
                                         longint qw, longint qx, longint qy, longint qz);
    pose_t  r;
    longint n2, one, acc;
    longint a[3][3], rc[3][3], rq[3][3], mt[3][3];
    longint p[3], g[3], wv[3];
    logic [47:0] rows[3];
    r = '0;
    n2 = qw*qw + qx*qx + qy*qy + qz*qz;
    if (n2 == 0) return r;
    one = longint'(1) << ROT_FRAC_BITS;
    rq[0][0] = one - quat_ratio(qy*qy + qz*qz, n2);
    rq[0][1] = quat_ratio(qx*qy - qz*qw, n2);
    rq[0][2] = quat_ratio(qx*qz + qy*qw, n2);
    rq[1][0] = quat_ratio(qx*qy + qz*qw, n2);
    rq[1][1] = one - quat_ratio(qx*qx + qz*qz, n2);
    rq[1][2] = quat_ratio(qy*qz - qx*qw, n2);
    rq[2][0] = quat_ratio(qx*qz - qy*qw, n2);
    rq[2][1] = quat_ratio(qy*qz + qx*qw, n2);
    rq[2][2] = one - quat_ratio(qx*qx + qy*qy, n2);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        rq[i][j] = clip(rq[i][j], 16);
        a[i][j]  = sx(regs[i] >> (16*j), 16);
        rc[i][j] = sx(regs[3+i] >> (16*j), 16);
      end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++)
          for (int l = 0; l < 3; l++) acc += a[k][i] * rq[k][l] * a[l][j];
        mt[i][j] = clip(round_shr(acc, 2*ROT_FRAC_BITS), 16);
      end
    p[0] = px; p[1] = py; p[2] = pz;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += rc[i][k] * p[k];
      g[i] = round_shr(acc, ROT_FRAC_BITS) + sx(regs[6] >> (20*i), 20);
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += mt[i][k] * g[k];
      wv[i] = round_shr(acc, ROT_FRAC_BITS);
      rows[i] = '0;
      for (int j = 0; j < 3; j++) rows[i][16*j +: 16] = mt[i][j][15:0];
    end
    r.ok = 1'b1;
    r.gx = 24'(clip(g[0], 24)); r.gy = 24'(clip(g[1], 24)); r.gz = 24'(clip(g[2], 24));
    r.wx = 24'(clip(wv[0], 24)); r.wy = 24'(clip(wv[1], 24)); r.wz = 24'(clip(wv[2], 24));
    r.r0 = rows[0]; r.r1 = rows[1]; r.r2 = rows[2];
    return r;
  endfunction

  task automatic cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t e;
    if (!rst_ni) begin
      for (int i = 0; i < 7; i++) regs[i] = '0;
      pending = pose_q.size();
    end else begin
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < 3'd7)
        regs[cfg_index_i] = cfg_index_i == CFG_CAM_OFF ? cfg_data_i : {12'd0, cfg_data_i[47:0]};
      if (out_valid_o && !out_stall_i) begin
        if (pose_q.size() == 0) begin
          $error("result transfer with no expectation pending");
          fail_count++;
        end else begin
          e = pose_q.pop_front();
          cmp("valid_res", e.ok, valid_res_o);
          cmp("gimbal_x", e.gx, $unsigned(gimbal_x_o));
          cmp("gimbal_y", e.gy, $unsigned(gimbal_y_o));
          cmp("gimbal_z", e.gz, $unsigned(gimbal_z_o));
          cmp("world_x", e.wx, $unsigned(world_x_o));
          cmp("world_y", e.wy, $unsigned(world_y_o));
          cmp("world_z", e.wz, $unsigned(world_z_o));
          cmp("world_rot_row0", e.r0, world_rot_row0_o);
          cmp("world_rot_row1", e.r1, world_rot_row1_o);
          cmp("world_rot_row2", e.r2, world_rot_row2_o);
        end
      end
      if (in_valid_i && !in_stall_o)
        pose_q.push_back(predict_pose(cam_x_i, cam_y_i, cam_z_i,
                                      quat_w_i, quat_x_i, quat_y_i, quat_z_i));
      pending = pose_q.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
// Testbench top for quaternion_rigid_point_transform: drives config, points
// and quaternions with random idling; verdict from qrpt_checker.
// Depends on qrpt_pkg, qrpt_checker and the RTL.
`timescale 1ns / 100ps

module tb;
  import qrpt_pkg::*;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic in_valid_i = 1'b0, out_stall_i = 1'b0, cfg_valid_i = 1'b0;
  logic signed [23:0] cam_x_i = '0, cam_y_i = '0, cam_z_i = '0;
  logic signed [15:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic [2:0]  cfg_index_i = '0;
  logic [59:0] cfg_data_i = '0;
  logic in_stall_o, out_valid_o, cfg_ready_o, valid_res_o;
  logic signed [23:0] gimbal_x_o, gimbal_y_o, gimbal_z_o, world_x_o, world_y_o, world_z_o;
  logic [47:0] world_rot_row0_o, world_rot_row1_o, world_rot_row2_o;
  int fail_count, pending;
  bit quiet;

  localparam int Latency = 24;

  always #4 clk_i = ~clk_i;

  quaternion_rigid_point_transform uut (.*);
  qrpt_checker chk (.*);

  // receiver stalls
  always @(negedge clk_i) out_stall_i <= !quiet && ($urandom_range(99) < 18);

  function automatic logic [47:0] pack_row(int e0, int e1, int e2);
    return {e2[15:0], e1[15:0], e0[15:0]};
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [59:0] data);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic load_frames(int mode);
    logic [59:0] v;
    for (int r = 0; r < 3; r++) begin
      case (mode)
        0: v = 60'd0;
        1: v = 60'(pack_row(r == 0 ? 16384 : 0, r == 1 ? 16384 : 0, r == 2 ? 16384 : 0));
        2: v = 60'(pack_row(32767, -32768, 32767));
        default: v = 60'({$urandom, $urandom});
      endcase
      write_reg(cfg_idx_e'(r), 60'(v[47:0]));
      if (mode == 2) v = 60'(pack_row(-32768, 32767, -32768));
      else if (mode == 3) v = 60'({$urandom, $urandom});
      write_reg(cfg_idx_e'(3 + r), 60'(v[47:0]));
    end
    case (mode)
      0: v = 60'd0;
      1: v = {20'sd65536, -20'sd32768, 20'sd1000};
      2: v = {20'h80000, 20'h7ffff, 20'h80000};
      default: v = 60'({$urandom, $urandom});
    endcase
    write_reg(CFG_CAM_OFF, v);
  endtask

  task automatic send_pose(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                           logic [15:0] w, logic [15:0] qx, logic [15:0] qy,
                           logic [15:0] qz, bit gaps);
    while (gaps && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cam_x_i <= x; cam_y_i <= y; cam_z_i <= z;
    quat_w_i <= w; quat_x_i <= qx; quat_y_i <= qy; quat_z_i <= qz;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic random_batch(int count, bit gaps);
    logic [15:0] q[4];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(3))
          0: q[i] = 16'($urandom);
          1: q[i] = 16'($urandom_range(16) - 8);
          2: q[i] = $urandom_range(1) ? 16'h8000 : 16'h7fff;
          default: q[i] = 16'($urandom_range(16384) - 8192);
        endcase
      end
      if ($urandom_range(19) == 0) q = '{16'd0, 16'd0, 16'd0, 16'd0};
      send_pose(24'($urandom), 24'($urandom), 24'($urandom), q[0], q[1], q[2], q[3], gaps);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    quiet = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    load_frames(1);
    send_pose(24'h7fffff, 24'h800000, 24'h000001, 16'h2000, 16'h0, 16'h0, 16'h0, 0);
    send_pose(24'h800000, 24'h7fffff, 24'hffffff, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    send_pose(24'h010000, 24'h020000, 24'h030000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
    send_pose(24'h000000, 24'hffffff, 24'h7fffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1);
    send_pose(24'h100000, 24'h0, 24'h0, 16'h0, 16'h0, 16'h0, 16'h1, 1);
    send_pose(24'h0, 24'h100000, 24'h0, 16'h1, 16'h1, 16'hffff, 16'h0, 1);
    send_pose(24'h0, 24'h0, 24'h100000, 16'h16a1, 16'h0, 16'h16a1, 16'h0, 1);
    send_pose(24'h123456, 24'hedcba9, 24'h555555, 16'h0, 16'h7fff, 16'h0, 16'h0, 1);
    in_valid_i <= 1'b0;
    drain();

    load_frames(2);
    random_batch(200, 1);
    drain();

    load_frames(0);
    random_batch(100, 1);
    drain();

    load_frames(3);
    quiet = 1'b1;
    random_batch(300, 0);
    quiet = 1'b0;
    random_batch(350, 1);
    drain();

    load_frames(3);
    random_batch(400, 1);
    drain();

    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
